>>> rtl/lsar_pkg.sv
// Shared types and constants for the light sensor auto-range block.
// Used by lsar_cfg, lsar_ladder and the top level; depends on nothing else.
`default_nettype none

package lsar_pkg;

	localparam int unsigned COUNT_W = 16;
	localparam int unsigned GAIN_W  = 2;
	localparam int unsigned TIME_W  = 3;
	localparam int unsigned REP_W   = 2;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [COUNT_W-1:0] COUNT_SAT    = 16'hFFFF;
	localparam logic [COUNT_W-1:0] DARK_RESET   = 16'd100;
	localparam logic [COUNT_W-1:0] BRIGHT_RESET = 16'd30000;

	localparam logic [GAIN_W-1:0] GAIN_LOW = 2'd0;
	localparam logic [GAIN_W-1:0] GAIN_MAX = 2'd3;

	localparam logic [TIME_W-1:0] TIME_100 = 3'd0;
	localparam logic [TIME_W-1:0] TIME_200 = 3'd1;
	localparam logic [TIME_W-1:0] TIME_600 = 3'd5;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DARK   = 1'b0,
		REG_BRIGHT = 1'b1
	} reg_idx_t;

	// Threshold pair handed from the register file to the ladder.
	typedef struct packed {
		logic [COUNT_W-1:0] dark;
		logic [COUNT_W-1:0] bright;
	} thresh_t;

	// Outcome of one ladder step: new setting, flags and next repeat count.
	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [TIME_W-1:0] tlev;
		logic              changed;
		logic              limit;
		logic              again;
		logic [REP_W-1:0]  rep;
	} step_t;

endpackage

`default_nettype wire

>>> rtl/lsar_cfg.sv
// Threshold register file of the light sensor auto-range block.
// Depends on lsar_pkg for widths, reset values and register indexes.
`default_nettype none

module lsar_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [lsar_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsar_pkg::COUNT_W-1:0]    cfg_data,
	output lsar_pkg::thresh_t                    thresh
);

	logic [lsar_pkg::COUNT_W-1:0] dark_q;
	logic [lsar_pkg::COUNT_W-1:0] bright_q;

	// Write one threshold per enabled cycle; the index selects which.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q   <= lsar_pkg::DARK_RESET;
			bright_q <= lsar_pkg::BRIGHT_RESET;
		end else if (cfg_we) begin
			case (lsar_pkg::reg_idx_t'(cfg_index))
				lsar_pkg::REG_DARK:   dark_q   <= cfg_data;
				lsar_pkg::REG_BRIGHT: bright_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign thresh.dark   = dark_q;
	assign thresh.bright = bright_q;

endmodule

`default_nettype wire

>>> rtl/lsar_ladder.sv
// Combinational ranging step: classifies one measurement and moves the
// gain / integration-time ladder one rung. Depends on lsar_pkg.
`default_nettype none

module lsar_ladder #(
	parameter int unsigned MAX_REPEATS = 3
) (
	input  wire logic [lsar_pkg::COUNT_W-1:0] vis,
	input  wire logic [lsar_pkg::COUNT_W-1:0] ir,
	input  wire lsar_pkg::thresh_t            thresh,
	input  wire logic [lsar_pkg::GAIN_W-1:0]  gain_cur,
	input  wire logic [lsar_pkg::TIME_W-1:0]  time_cur,
	input  wire logic [lsar_pkg::REP_W-1:0]   rep_cur,
	output lsar_pkg::step_t                   step
);

	logic dark;
	logic bright;

	// Dark takes priority; saturation on either channel counts as bright.
	assign dark   = vis < thresh.dark;
	assign bright = (vis > thresh.bright) || (vis == lsar_pkg::COUNT_SAT) ||
		(ir == lsar_pkg::COUNT_SAT);

	// Ladder: gain moves first and sets 200 ms; time steps only at the gain extremes.
	always_comb begin
		step.gain    = gain_cur;
		step.tlev    = time_cur;
		step.changed = 1'b0;
		step.limit   = 1'b0;
		if (dark) begin
			if (gain_cur != lsar_pkg::GAIN_MAX) begin
				step.gain    = gain_cur + 2'd1;
				step.tlev    = lsar_pkg::TIME_200;
				step.changed = 1'b1;
			end else if (time_cur < lsar_pkg::TIME_600) begin
				step.tlev    = time_cur + 3'd1;
				step.changed = 1'b1;
			end else if (time_cur == lsar_pkg::TIME_600) begin
				step.limit   = 1'b1;
			end else begin
				// Out-of-range time level snaps back to the longest time.
				step.tlev    = lsar_pkg::TIME_600;
				step.changed = 1'b1;
			end
		end else if (bright) begin
			if (gain_cur != lsar_pkg::GAIN_LOW) begin
				step.gain    = gain_cur - 2'd1;
				step.tlev    = lsar_pkg::TIME_200;
				step.changed = 1'b1;
			end else if (time_cur == lsar_pkg::TIME_100) begin
				step.limit   = 1'b1;
			end else if (time_cur <= lsar_pkg::TIME_600) begin
				step.tlev    = time_cur - 3'd1;
				step.changed = 1'b1;
			end else begin
				// Out-of-range time level snaps back to the shortest time.
				step.tlev    = lsar_pkg::TIME_100;
				step.changed = 1'b1;
			end
		end

		// Re-measure chain: count requests in a row, end the chain otherwise.
		step.again = step.changed && (rep_cur < lsar_pkg::REP_W'(MAX_REPEATS));
		step.rep   = step.again ? (rep_cur + 2'd1) : '0;
	end

endmodule

`default_nettype wire

>>> rtl/light_sensor_auto_range.sv
// Light sensor automatic gain and integration-time ranging block.
// Top level; depends on lsar_pkg, lsar_cfg and lsar_ladder.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one measurement per
//    transaction: visible_count and infrared_count.
//  - Output channel (out_valid / out_stall) carries one result per
//    measurement: new gain and time levels, changed, limit and re-measure.
//  - Thresholds are written through cfg_we / cfg_index / cfg_data while
//    the block is idle; they apply to every later measurement.
//  - Path: an accepted measurement is held in the input register, and its
//    result is then loaded into the result register.
//  - Throughput: one measurement per cycle unless the receiver stalls. The
//    gain, time and repeat registers are updated in the same cycle as the
//    result register, so the next measurement sees the new setting at once.
//  - Reset clears both pipeline stages, sets low gain, 100 ms and a zero
//    repeat count, and loads the default thresholds (100 and 30000).
//  - While the receiver stalls, the held result stays unchanged; one more
//    measurement is taken into the input register, after which in_stall
//    is raised until the result is taken.
`default_nettype none

module light_sensor_auto_range #(
	parameter int unsigned MAX_REPEATS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] visible_count,
	input  wire logic [15:0] infrared_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       gain_level,
	output logic [2:0]       time_level,
	output logic             setting_changed,
	output logic             limit_reached,
	output logic             remeasure
);

	lsar_pkg::thresh_t thresh;
	lsar_pkg::step_t   step;

	logic                          valid_s1;
	logic [lsar_pkg::COUNT_W-1:0]  vis_s1;
	logic [lsar_pkg::COUNT_W-1:0]  ir_s1;
	logic [lsar_pkg::GAIN_W-1:0]   gain_q;
	logic [lsar_pkg::TIME_W-1:0]   time_q;
	logic [lsar_pkg::REP_W-1:0]    rep_q;
	logic                          out_valid_q;
	lsar_pkg::step_t               res_q;
	logic                          out_free;
	logic                          advance;
	logic                          in_take;

	lsar_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thresh    (thresh)
	);

	lsar_ladder #(
		.MAX_REPEATS (MAX_REPEATS)
	) u_ladder (
		.vis      (vis_s1),
		.ir       (ir_s1),
		.thresh   (thresh),
		.gain_cur (gain_q),
		.time_cur (time_q),
		.rep_cur  (rep_q),
		.step     (step)
	);

	// Handshake: the result register frees when empty or being taken.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			vis_s1 <= visible_count;
			ir_s1  <= infrared_count;
		end
	end

	// Ranging state, updated as each measurement completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= lsar_pkg::GAIN_LOW;
			time_q <= lsar_pkg::TIME_100;
			rep_q  <= '0;
		end else if (advance) begin
			gain_q <= step.gain;
			time_q <= step.tlev;
			rep_q  <= step.rep;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step;
		end
	end

	assign out_valid       = out_valid_q;
	assign gain_level      = res_q.gain;
	assign time_level      = res_q.tlev;
	assign setting_changed = res_q.changed;
	assign limit_reached   = res_q.limit;
	assign remeasure       = res_q.again;

endmodule

`default_nettype wire

>>> rtl/lsar_checker.sv
// Port-level checks for the light sensor auto-range block, bound to the
// top level. Depends only on the top level's ports.
`default_nettype none

module lsar_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  gain_level,
	input wire logic [2:0]  time_level,
	input wire logic        setting_changed,
	input wire logic        limit_reached,
	input wire logic        remeasure
);

	// A stalled result stays offered.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	// A stalled result keeps its setting.
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(gain_level) && $stable(time_level))
		else $error("result payload changed while stalled");

	// Input back-pressure only arises from a stalled, full output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// A re-measure request only follows a change, never a limit hit.
	a_remeasure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && remeasure |-> setting_changed && !limit_reached)
		else $error("re-measure without a setting change");

	// The ladder never leaves the 100 to 600 ms range.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> time_level <= 3'd5)
		else $error("integration time level out of range");

endmodule

bind light_sensor_auto_range lsar_checker u_lsar_checker (.*);

`default_nettype wire
